/* rtl/npt_pkg.sv */
// ----------------------------------------------------------------------------
// npt_pkg
// Shared types, codes and constants of the nearest point table unit.
// ----------------------------------------------------------------------------
package npt_pkg;

    // default parameter values
    localparam int MAX_POINTS_DEF = 16;
    localparam int COORD_BITS_DEF = 16;
    localparam int DIST_SHIFT_DEF = 4;

    // fixed field widths
    localparam int FUNC_BITS   = 3;
    localparam int FIELD_BITS  = 16;
    localparam int INDEX_BITS  = 4;
    localparam int STATUS_BITS = 2;
    localparam int DIST_BITS   = 25;
    localparam int COUNT_BITS  = 5;
    localparam int TAKEN_BITS  = 8;

    localparam logic [TAKEN_BITS-1:0] TAKEN_MAX = 8'd255;

    // operation codes
    localparam logic [FUNC_BITS-1:0] FUNC_FIND   = 3'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_REMOVE = 3'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_TAKE   = 3'd2;
    localparam logic [FUNC_BITS-1:0] FUNC_APPEND = 3'd3;
    localparam logic [FUNC_BITS-1:0] FUNC_REINIT = 3'd4;

    // result status codes
    localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_BAD   = 2'd2;

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FALLBACK_X = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FALLBACK_Y = 1'd1;

    localparam logic signed [FIELD_BITS-1:0] FALLBACK_X_RST = 16'sd0;
    localparam logic signed [FIELD_BITS-1:0] FALLBACK_Y_RST = 16'sd100;

    // built-in positions
    localparam int BUILTIN_COUNT = 12;
    localparam logic signed [FIELD_BITS-1:0] BUILTIN_X [BUILTIN_COUNT] = '{
        -16'sd60, -16'sd30, 16'sd30, 16'sd60, -16'sd45, -16'sd15,
        16'sd15, 16'sd45, -16'sd60, -16'sd30, 16'sd30, 16'sd60
    };
    localparam logic signed [FIELD_BITS-1:0] BUILTIN_Y [BUILTIN_COUNT] = '{
        16'sd95, 16'sd95, 16'sd95, 16'sd95, 16'sd120, 16'sd120,
        16'sd120, 16'sd120, 16'sd145, 16'sd145, 16'sd145, 16'sd145
    };

    // table read address select
    localparam logic [1:0] RD_SCAN = 2'd0;
    localparam logic [1:0] RD_IDX  = 2'd1;
    localparam logic [1:0] RD_LAST = 2'd2;

    // table write select
    localparam logic [1:0] WR_LOAD   = 2'd0;
    localparam logic [1:0] WR_IDX    = 2'd1;
    localparam logic [1:0] WR_LAST   = 2'd2;
    localparam logic [1:0] WR_APPEND = 2'd3;

    // result select
    localparam logic [2:0] RES_ZERO     = 3'd0;
    localparam logic [2:0] RES_FALLBACK = 3'd1;
    localparam logic [2:0] RES_BAD      = 3'd2;
    localparam logic [2:0] RES_FIND     = 3'd3;
    localparam logic [2:0] RES_SWAP     = 3'd4;
    localparam logic [2:0] RES_APPEND   = 3'd5;

    // controller to datapath commands
    typedef struct packed {
        logic       cap_in;
        logic [1:0] rd_sel;
        logic       hold_cap;
        logic       scan_clear;
        logic       scan_step;
        logic       wr_en;
        logic [1:0] wr_sel;
        logic       ld_write;
        logic       res_load;
        logic [2:0] res_sel;
        logic       push;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic [FUNC_BITS-1:0] func;
        logic                 empty;
        logic                 full;
        logic                 idx_ok;
        logic                 scan_last;
        logic                 pipe_busy;
        logic                 ld_last;
        logic                 out_blocked;
    } t_dp_status;

endpackage

/* rtl/npt_in_if.sv */
// ----------------------------------------------------------------------------
// npt_in_if
// Command word channel into the nearest point table unit.
// ----------------------------------------------------------------------------
interface npt_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic signed [15:0] query_x;
    logic signed [15:0] query_y;
    logic [3:0]         entry_index;
    logic signed [15:0] new_x;
    logic signed [15:0] new_y;

    modport source (
        output valid, func, query_x, query_y, entry_index, new_x, new_y,
        input  ready
    );
    modport sink (
        input  valid, func, query_x, query_y, entry_index, new_x, new_y,
        output ready
    );
endinterface

/* rtl/npt_out_if.sv */
// ----------------------------------------------------------------------------
// npt_out_if
// Result word channel out of the nearest point table unit.
// ----------------------------------------------------------------------------
interface npt_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [3:0]         found_index;
    logic signed [15:0] found_x;
    logic signed [15:0] found_y;
    logic [24:0]        best_distance;
    logic [4:0]         live_count;
    logic [7:0]         taken_count;

    modport source (
        output valid, status, found_index, found_x, found_y, best_distance,
               live_count, taken_count,
        input  ready
    );
    modport sink (
        input  valid, status, found_index, found_x, found_y, best_distance,
               live_count, taken_count,
        output ready
    );
endinterface

/* rtl/nearest_point_table_unit.sv */
// Find: one slot per cycle over the live slots, then the distance pipeline drains.
// Remove/take: two reads, then two writes on the point memory port.
// Append: the new point is written at decode. Reinitialise: one built-in point per cycle.
// One word in flight; the next is accepted once the controller is idle again.
// Reset: synchronous; a load of the built-in points follows, with no input taken.
// ----------------------------------------------------------------------------
// nearest_point_table_unit
// Table of signed 2-D points with nearest search, swap removal, append and
// reload of built-in positions.
// ----------------------------------------------------------------------------
module nearest_point_table_unit
    import npt_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int DIST_SHIFT = DIST_SHIFT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    npt_in_if.sink                       i_in,
    npt_out_if.source                    o_out,
    input  logic                         i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  logic signed [FIELD_BITS-1:0] i_cfg_data
);

    t_dp_cmd    w_cmd;
    t_dp_status w_st;
    logic       w_in_ready;

    assign i_in.ready = w_in_ready;

    // sequencer
    npt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_st       (w_st),
        .o_cmd      (w_cmd)
    );

    // datapath
    npt_dp #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS),
        .DIST_SHIFT (DIST_SHIFT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_st            (w_st),
        .i_func          (i_in.func),
        .i_query_x       (i_in.query_x),
        .i_query_y       (i_in.query_y),
        .i_entry_index   (i_in.entry_index),
        .i_new_x         (i_in.new_x),
        .i_new_y         (i_in.new_y),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_status        (o_out.status),
        .o_found_index   (o_out.found_index),
        .o_found_x       (o_out.found_x),
        .o_found_y       (o_out.found_y),
        .o_best_distance (o_out.best_distance),
        .o_live_count    (o_out.live_count),
        .o_taken_count   (o_out.taken_count)
    );

endmodule

/* rtl/npt_ctrl.sv */
// ----------------------------------------------------------------------------
// npt_ctrl
// Sequencer of the nearest point table: decodes one command word at a time
// and steps the datapath through scan, swap, append and load sequences.
// ----------------------------------------------------------------------------
module npt_ctrl
    import npt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_st,
    output t_dp_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_SCAN   = 4'd2;
    localparam logic [3:0] S_DRAIN  = 4'd3;
    localparam logic [3:0] S_SWAP_A = 4'd4;
    localparam logic [3:0] S_SWAP_B = 4'd5;
    localparam logic [3:0] S_SWAP_C = 4'd6;
    localparam logic [3:0] S_SWAP_D = 4'd7;
    localparam logic [3:0] S_LOAD   = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_reply;
    logic       n_reply;

    // state and load reply flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_reply <= 1'b0;
        end else begin
            r_state <= n_state;
            r_reply <= n_reply;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_reply = r_reply;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap_in = 1'b1;
                    n_state      = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_st.func)
                    FUNC_FIND: begin
                        if (i_st.empty) begin
                            o_cmd.res_load = 1'b1;
                            o_cmd.res_sel  = RES_FALLBACK;
                            n_state        = S_DONE;
                        end else begin
                            o_cmd.scan_clear = 1'b1;
                            n_state          = S_SCAN;
                        end
                    end
                    FUNC_REMOVE, FUNC_TAKE: begin
                        if (i_st.idx_ok) begin
                            n_state = S_SWAP_A;
                        end else begin
                            o_cmd.res_load = 1'b1;
                            o_cmd.res_sel  = RES_BAD;
                            n_state        = S_DONE;
                        end
                    end
                    FUNC_APPEND: begin
                        o_cmd.res_load = 1'b1;
                        if (i_st.full) begin
                            o_cmd.res_sel = RES_BAD;
                        end else begin
                            o_cmd.res_sel = RES_APPEND;
                            o_cmd.wr_en   = 1'b1;
                            o_cmd.wr_sel  = WR_APPEND;
                        end
                        n_state = S_DONE;
                    end
                    FUNC_REINIT: begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_sel  = RES_ZERO;
                        n_reply        = 1'b1;
                        n_state        = S_LOAD;
                    end
                    default: begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_sel  = RES_ZERO;
                        n_state        = S_DONE;
                    end
                endcase
            end
            S_SCAN: begin
                o_cmd.rd_sel    = RD_SCAN;
                o_cmd.scan_step = 1'b1;
                if (i_st.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_st.pipe_busy) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = RES_FIND;
                    n_state        = S_DONE;
                end
            end
            S_SWAP_A: begin
                o_cmd.rd_sel = RD_IDX;
                n_state      = S_SWAP_B;
            end
            S_SWAP_B: begin
                o_cmd.rd_sel   = RD_LAST;
                o_cmd.hold_cap = 1'b1;
                n_state        = S_SWAP_C;
            end
            S_SWAP_C: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_IDX;
                n_state      = S_SWAP_D;
            end
            S_SWAP_D: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.wr_sel   = WR_LAST;
                o_cmd.res_load = 1'b1;
                o_cmd.res_sel  = RES_SWAP;
                n_state        = S_DONE;
            end
            S_LOAD: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.wr_sel   = WR_LOAD;
                o_cmd.ld_write = 1'b1;
                if (i_st.ld_last) begin
                    n_reply = 1'b0;
                    n_state = r_reply ? S_DONE : S_IDLE;
                end
            end
            S_DONE: begin
                if (!i_st.out_blocked) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/npt_dp.sv */
// ----------------------------------------------------------------------------
// npt_dp
// Datapath of the nearest point table: point memory, counters, distance
// pipeline with best tracking, result and output registers.
// ----------------------------------------------------------------------------
module npt_dp
    import npt_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int DIST_SHIFT = DIST_SHIFT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_dp_cmd                       i_cmd,
    output t_dp_status                    o_st,
    input  logic [FUNC_BITS-1:0]          i_func,
    input  logic signed [FIELD_BITS-1:0]  i_query_x,
    input  logic signed [FIELD_BITS-1:0]  i_query_y,
    input  logic [INDEX_BITS-1:0]         i_entry_index,
    input  logic signed [FIELD_BITS-1:0]  i_new_x,
    input  logic signed [FIELD_BITS-1:0]  i_new_y,
    input  logic                          i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]     i_cfg_index,
    input  logic signed [FIELD_BITS-1:0]  i_cfg_data,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [STATUS_BITS-1:0]        o_status,
    output logic [INDEX_BITS-1:0]         o_found_index,
    output logic signed [FIELD_BITS-1:0]  o_found_x,
    output logic signed [FIELD_BITS-1:0]  o_found_y,
    output logic [DIST_BITS-1:0]          o_best_distance,
    output logic [COUNT_BITS-1:0]         o_live_count,
    output logic [TAKEN_BITS-1:0]         o_taken_count
);

    localparam int CB    = COORD_BITS;
    localparam int IW    = $clog2(MAX_POINTS);
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int MW    = (CB > DIST_SHIFT) ? (CB - DIST_SHIFT) : 1;
    localparam int DW    = 2 * MW + 1;
    localparam int DEXT  = (DW > DIST_BITS) ? DW : DIST_BITS;
    localparam int NLOAD = (BUILTIN_COUNT < MAX_POINTS) ? BUILTIN_COUNT : MAX_POINTS;
    localparam int LW    = $clog2(NLOAD);

    // field to coordinate, sign-extended or truncated
    function automatic logic signed [CB-1:0] f_coord(input logic signed [FIELD_BITS-1:0] v);
        logic signed [31:0] e;
        e = 32'(v);
        return e[CB-1:0];
    endfunction

    // coordinate back to a 16-bit field
    function automatic logic signed [FIELD_BITS-1:0] f_field(input logic signed [CB-1:0] c);
        logic signed [31:0] e;
        e = 32'(c);
        return e[FIELD_BITS-1:0];
    endfunction

    // captured command word
    logic [FUNC_BITS-1:0]  r_func;
    logic signed [CB-1:0]  r_qx, r_qy, r_nx, r_ny;
    logic [INDEX_BITS-1:0] r_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_func <= i_func;
            r_qx   <= f_coord(i_query_x);
            r_qy   <= f_coord(i_query_y);
            r_idx  <= i_entry_index;
            r_nx   <= f_coord(i_new_x);
            r_ny   <= f_coord(i_new_y);
        end
    end

    // fallback registers
    logic signed [CB-1:0] r_fb_x, r_fb_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb_x <= f_coord(FALLBACK_X_RST);
            r_fb_y <= f_coord(FALLBACK_Y_RST);
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_FALLBACK_X) begin
                r_fb_x <= f_coord(i_cfg_data);
            end
            if (i_cfg_index == CFG_FALLBACK_Y) begin
                r_fb_y <= f_coord(i_cfg_data);
            end
        end
    end

    // counters
    logic [CW-1:0]         r_count;
    logic [TAKEN_BITS-1:0] r_taken;
    logic [LW-1:0]         r_ld_cnt;
    logic [CW-1:0]         r_scan_cnt;
    logic                  w_ld_last;
    logic [CW-1:0]         w_last_cnt;
    logic [CW-1:0]         w_scan_next;

    assign w_ld_last   = (r_ld_cnt == LW'(NLOAD - 1));
    assign w_last_cnt  = r_count - CW'(1);
    assign w_scan_next = r_scan_cnt + CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= CW'(NLOAD);
            r_taken    <= '0;
            r_ld_cnt   <= '0;
            r_scan_cnt <= '0;
        end else begin
            if (i_cmd.ld_write) begin
                if (w_ld_last) begin
                    r_ld_cnt <= '0;
                    r_count  <= CW'(NLOAD);
                    r_taken  <= '0;
                end else begin
                    r_ld_cnt <= r_ld_cnt + LW'(1);
                end
            end
            if (i_cmd.wr_en && i_cmd.wr_sel == WR_APPEND) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.wr_en && i_cmd.wr_sel == WR_LAST) begin
                r_count <= w_last_cnt;
                if (r_func == FUNC_TAKE && r_taken != TAKEN_MAX) begin
                    r_taken <= r_taken + TAKEN_BITS'(1);
                end
            end
            if (i_cmd.scan_clear) begin
                r_scan_cnt <= '0;
            end else if (i_cmd.scan_step) begin
                r_scan_cnt <= w_scan_next;
            end
        end
    end

    // table addresses
    logic [31:0]   w_idx32, w_ld32;
    logic [IW-1:0] w_idx_addr, w_ld_addr, w_last_addr, w_app_addr;

    assign w_idx32     = 32'(r_idx);
    assign w_ld32      = 32'(r_ld_cnt);
    assign w_idx_addr  = w_idx32[IW-1:0];
    assign w_ld_addr   = w_ld32[IW-1:0];
    assign w_last_addr = w_last_cnt[IW-1:0];
    assign w_app_addr  = r_count[IW-1:0];

    logic [IW-1:0]        w_rd_addr, w_wr_addr;
    logic signed [CB-1:0] w_wr_x, w_wr_y;
    logic signed [CB-1:0] r_rd_x, r_rd_y;
    logic signed [CB-1:0] r_hold_x, r_hold_y;

    // read address select
    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_SCAN: w_rd_addr = r_scan_cnt[IW-1:0];
            RD_IDX:  w_rd_addr = w_idx_addr;
            RD_LAST: w_rd_addr = w_last_addr;
            default: w_rd_addr = r_scan_cnt[IW-1:0];
        endcase
    end

    // write address and data select
    always_comb begin
        unique case (i_cmd.wr_sel)
            WR_LOAD: begin
                w_wr_addr = w_ld_addr;
                w_wr_x    = f_coord(BUILTIN_X[r_ld_cnt]);
                w_wr_y    = f_coord(BUILTIN_Y[r_ld_cnt]);
            end
            WR_IDX: begin
                w_wr_addr = w_idx_addr;
                w_wr_x    = r_rd_x;
                w_wr_y    = r_rd_y;
            end
            WR_LAST: begin
                w_wr_addr = w_last_addr;
                w_wr_x    = r_hold_x;
                w_wr_y    = r_hold_y;
            end
            WR_APPEND: begin
                w_wr_addr = w_app_addr;
                w_wr_x    = r_nx;
                w_wr_y    = r_ny;
            end
        endcase
    end

    // point memory, registered read
    logic signed [CB-1:0] r_mem_x [MAX_POINTS];
    logic signed [CB-1:0] r_mem_y [MAX_POINTS];

    always_ff @(posedge i_clk) begin
        r_rd_x <= r_mem_x[w_rd_addr];
        r_rd_y <= r_mem_y[w_rd_addr];
        if (i_cmd.wr_en) begin
            r_mem_x[w_wr_addr] <= w_wr_x;
            r_mem_y[w_wr_addr] <= w_wr_y;
        end
    end

    // hold the point leaving its slot during a swap
    always_ff @(posedge i_clk) begin
        if (i_cmd.hold_cap) begin
            r_hold_x <= r_rd_x;
            r_hold_y <= r_rd_y;
        end
    end

    // distance pipeline: read, magnitude, square, sum and compare
    logic                 r_pa_v, r_pb_v, r_pc_v;
    logic [IW-1:0]        r_pa_idx, r_pb_idx, r_pc_idx, r_best_idx;
    logic signed [CB-1:0] r_pb_x, r_pb_y, r_pc_x, r_pc_y, r_best_x, r_best_y;
    logic [MW-1:0]        r_pb_mx, r_pb_my;
    logic [2*MW-1:0]      r_pc_sx, r_pc_sy;
    logic [DW-1:0]        r_best_dist;

    logic signed [CB:0] w_dx, w_dy;
    logic [CB:0]        w_ax, w_ay;
    logic [CB-1:0]      w_shx, w_shy;
    logic [DW-1:0]      w_sum;

    // truncation toward zero is a shift of the magnitude
    always_comb begin
        w_dx  = (CB+1)'(r_qx) - (CB+1)'(r_rd_x);
        w_dy  = (CB+1)'(r_qy) - (CB+1)'(r_rd_y);
        w_ax  = w_dx[CB] ? $unsigned(-w_dx) : $unsigned(w_dx);
        w_ay  = w_dy[CB] ? $unsigned(-w_dy) : $unsigned(w_dy);
        w_shx = w_ax[CB-1:0] >> DIST_SHIFT;
        w_shy = w_ay[CB-1:0] >> DIST_SHIFT;
        w_sum = DW'(r_pc_sx) + DW'(r_pc_sy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pa_v <= 1'b0;
            r_pb_v <= 1'b0;
            r_pc_v <= 1'b0;
        end else begin
            r_pa_v <= i_cmd.scan_step;
            r_pb_v <= r_pa_v;
            r_pc_v <= r_pb_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pa_idx <= r_scan_cnt[IW-1:0];
        r_pb_idx <= r_pa_idx;
        r_pb_x   <= r_rd_x;
        r_pb_y   <= r_rd_y;
        r_pb_mx  <= w_shx[MW-1:0];
        r_pb_my  <= w_shy[MW-1:0];
        r_pc_idx <= r_pb_idx;
        r_pc_x   <= r_pb_x;
        r_pc_y   <= r_pb_y;
        r_pc_sx  <= r_pb_mx * r_pb_mx;
        r_pc_sy  <= r_pb_my * r_pb_my;
        // first slot always taken, later ones only when strictly nearer
        if (r_pc_v && (r_pc_idx == '0 || w_sum < r_best_dist)) begin
            r_best_idx  <= r_pc_idx;
            r_best_x    <= r_pc_x;
            r_best_y    <= r_pc_y;
            r_best_dist <= w_sum;
        end
    end

    // result register
    logic [STATUS_BITS-1:0] r_res_status;
    logic [INDEX_BITS-1:0]  r_res_idx;
    logic signed [CB-1:0]   r_res_x, r_res_y;
    logic [DW-1:0]          r_res_dist;
    logic [31:0]            w_best32, w_app32;

    assign w_best32 = 32'(r_best_idx);
    assign w_app32  = 32'(r_count);

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res_status <= STATUS_OK;
            r_res_idx    <= '0;
            r_res_x      <= '0;
            r_res_y      <= '0;
            r_res_dist   <= '0;
            unique case (i_cmd.res_sel)
                RES_ZERO: begin
                end
                RES_FALLBACK: begin
                    r_res_status <= STATUS_EMPTY;
                    r_res_x      <= r_fb_x;
                    r_res_y      <= r_fb_y;
                end
                RES_BAD: begin
                    r_res_status <= STATUS_BAD;
                end
                RES_FIND: begin
                    r_res_idx  <= w_best32[INDEX_BITS-1:0];
                    r_res_x    <= r_best_x;
                    r_res_y    <= r_best_y;
                    r_res_dist <= r_best_dist;
                end
                RES_SWAP: begin
                    r_res_idx <= r_idx;
                    r_res_x   <= r_hold_x;
                    r_res_y   <= r_hold_y;
                end
                RES_APPEND: begin
                    r_res_idx <= w_app32[INDEX_BITS-1:0];
                    r_res_x   <= r_nx;
                    r_res_y   <= r_ny;
                end
                default: begin
                end
            endcase
        end
    end

    // output register
    logic [DEXT-1:0] w_dist_ext;
    logic [31:0]     w_cnt32;

    assign w_dist_ext = DEXT'(r_res_dist);
    assign w_cnt32    = 32'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            o_status        <= r_res_status;
            o_found_index   <= r_res_idx;
            o_found_x       <= f_field(r_res_x);
            o_found_y       <= f_field(r_res_y);
            o_best_distance <= w_dist_ext[DIST_BITS-1:0];
            o_live_count    <= w_cnt32[COUNT_BITS-1:0];
            o_taken_count   <= r_taken;
        end
    end

    // status to the controller
    always_comb begin
        o_st.func        = r_func;
        o_st.empty       = (r_count == '0);
        o_st.full        = (r_count == CW'(MAX_POINTS));
        o_st.idx_ok      = (w_idx32 < w_cnt32);
        o_st.scan_last   = (w_scan_next == r_count);
        o_st.pipe_busy   = r_pa_v | r_pb_v | r_pc_v;
        o_st.ld_last     = w_ld_last;
        o_st.out_blocked = o_out_valid & ~i_out_ready;
    end

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the nearest point table unit. Command words are
// queued up front, driven with random gaps and scored against an in-bench
// model of the point table: nearest search, swap removal, take, append,
// reload and the fallback answer of an empty table.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import npt_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 40;
    localparam int REPORT_LIMIT   = 10;

    localparam logic signed [FIELD_BITS-1:0] COORD_MIN = 16'sh8000;
    localparam logic signed [FIELD_BITS-1:0] COORD_MAX = 16'sh7FFF;

    // one command word and one result word
    typedef struct {
        logic [FUNC_BITS-1:0]         func;
        logic signed [FIELD_BITS-1:0] qx;
        logic signed [FIELD_BITS-1:0] qy;
        logic [INDEX_BITS-1:0]        idx;
        logic signed [FIELD_BITS-1:0] nx;
        logic signed [FIELD_BITS-1:0] ny;
    } t_table_cmd;

    typedef struct {
        logic [STATUS_BITS-1:0]       status;
        logic [INDEX_BITS-1:0]        slot;
        logic signed [FIELD_BITS-1:0] x;
        logic signed [FIELD_BITS-1:0] y;
        logic [DIST_BITS-1:0]         distance;
        logic [COUNT_BITS-1:0]        live;
        logic [TAKEN_BITS-1:0]        taken;
    } t_table_answer;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [CFG_INDEX_BITS-1:0]    i_cfg_index;
    logic signed [FIELD_BITS-1:0] i_cfg_data;

    npt_in_if  cmd_if ();
    npt_out_if res_if ();

    nearest_point_table_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (cmd_if),
        .o_out       (res_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // model of the point table
    logic signed [FIELD_BITS-1:0] pt_x [MAX_POINTS_DEF];
    logic signed [FIELD_BITS-1:0] pt_y [MAX_POINTS_DEF];
    int unsigned                  pt_live;
    logic [TAKEN_BITS-1:0]        pt_taken;
    logic signed [FIELD_BITS-1:0] fb_x = FALLBACK_X_RST;
    logic signed [FIELD_BITS-1:0] fb_y = FALLBACK_Y_RST;

    // stimulus and scoreboard
    t_table_cmd    cmd_backlog [$];
    t_table_answer answers_due [$];
    t_table_cmd    cur_cmd;
    t_table_answer want;
    int            plan_live;
    int            cmds_queued;
    int            cmds_taken;
    int            results_seen;
    int            fail_count;
    int            fallback_answers;
    int            rejected_cmds;
    int            settings_used;
    logic [TAKEN_BITS-1:0] taken_peak;

    // idling and back-pressure control
    int   src_idle_pct;
    int   snk_idle_pct;
    logic hold_req;
    int   hold_left;
    int   quiet_cycles;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void load_builtin();
        for (int i = 0; i < BUILTIN_COUNT; i++) begin
            pt_x[i] = BUILTIN_X[i];
            pt_y[i] = BUILTIN_Y[i];
        end
        pt_live  = BUILTIN_COUNT;
        pt_taken = '0;
    endfunction

    // per-axis term: difference scaled down with truncation toward zero, squared
    function automatic longint scaled_sq(logic signed [FIELD_BITS-1:0] a,
                                         logic signed [FIELD_BITS-1:0] b);
        longint q;
        q = (longint'(a) - longint'(b)) / (longint'(1) << DIST_SHIFT_DEF);
        return q * q;
    endfunction

    // apply one command word to the model, return the result word it gives
    function automatic t_table_answer table_apply(t_table_cmd c);
        t_table_answer a;
        longint d;
        longint bd;
        int best;
        int last;
        logic signed [FIELD_BITS-1:0] tx;
        logic signed [FIELD_BITS-1:0] ty;
        a = '{default: '0};
        case (c.func)
            FUNC_FIND: begin
                if (pt_live == 0) begin
                    a.status = STATUS_EMPTY;
                    a.x = fb_x;
                    a.y = fb_y;
                end else begin
                    bd = 0;
                    best = 0;
                    // only a strictly smaller distance wins, so ties keep the lower slot
                    for (int i = 0; i < pt_live; i++) begin
                        d = scaled_sq(c.qx, pt_x[i]) + scaled_sq(c.qy, pt_y[i]);
                        if (i == 0 || d < bd) begin
                            bd = d;
                            best = i;
                        end
                    end
                    a.slot = INDEX_BITS'(best);
                    a.x = pt_x[best];
                    a.y = pt_y[best];
                    a.distance = DIST_BITS'(bd);
                end
            end
            FUNC_REMOVE, FUNC_TAKE: begin
                if (c.idx >= pt_live) begin
                    a.status = STATUS_BAD;
                end else begin
                    // swap with the last live slot, then shrink
                    last = pt_live - 1;
                    tx = pt_x[last];
                    ty = pt_y[last];
                    a.slot = c.idx;
                    a.x = pt_x[c.idx];
                    a.y = pt_y[c.idx];
                    pt_x[last] = a.x;
                    pt_y[last] = a.y;
                    pt_x[c.idx] = tx;
                    pt_y[c.idx] = ty;
                    pt_live = last;
                    if (c.func == FUNC_TAKE && pt_taken < TAKEN_MAX) pt_taken++;
                end
            end
            FUNC_APPEND: begin
                if (pt_live >= MAX_POINTS_DEF) begin
                    a.status = STATUS_BAD;
                end else begin
                    pt_x[pt_live] = c.nx;
                    pt_y[pt_live] = c.ny;
                    a.slot = INDEX_BITS'(pt_live);
                    a.x = c.nx;
                    a.y = c.ny;
                    pt_live++;
                end
            end
            FUNC_REINIT: begin
                load_builtin();
            end
            default: begin
            end
        endcase
        a.live  = COUNT_BITS'(pt_live);
        a.taken = pt_taken;
        return a;
    endfunction

    // coordinate biased towards the extremes and the built-in area
    function automatic logic signed [FIELD_BITS-1:0] rand_coord();
        int r;
        r = $urandom_range(9);
        if (r == 0) return COORD_MIN;
        if (r == 1) return COORD_MAX;
        if (r < 6) return FIELD_BITS'($urandom_range(500)) - 16'sd200;
        return FIELD_BITS'($urandom);
    endfunction

    // mostly a live slot, sometimes anything
    function automatic logic [INDEX_BITS-1:0] pick_index();
        if (plan_live != 0 && $urandom_range(99) < 85)
            return INDEX_BITS'($urandom_range(plan_live - 1));
        return INDEX_BITS'($urandom);
    endfunction

    // queue one word; fields the operation ignores stay random
    task automatic queue_op(logic [FUNC_BITS-1:0] f, logic signed [FIELD_BITS-1:0] x,
                            logic signed [FIELD_BITS-1:0] y, logic [INDEX_BITS-1:0] idx);
        t_table_cmd c;
        c.func = f;
        c.qx   = FIELD_BITS'($urandom);
        c.qy   = FIELD_BITS'($urandom);
        c.idx  = INDEX_BITS'($urandom);
        c.nx   = FIELD_BITS'($urandom);
        c.ny   = FIELD_BITS'($urandom);
        case (f)
            FUNC_FIND: begin
                c.qx = x;
                c.qy = y;
            end
            FUNC_APPEND: begin
                c.nx = x;
                c.ny = y;
            end
            FUNC_REMOVE, FUNC_TAKE: begin
                c.idx = idx;
            end
            default: begin
            end
        endcase
        // track the live count so that sequences can be shaped ahead of time
        if (f == FUNC_APPEND) begin
            if (plan_live < MAX_POINTS_DEF) plan_live++;
        end else if (f == FUNC_REMOVE || f == FUNC_TAKE) begin
            if (idx < plan_live) plan_live--;
        end else if (f == FUNC_REINIT) begin
            plan_live = BUILTIN_COUNT;
        end
        cmd_backlog.push_back(c);
        cmds_queued++;
    endtask

    task automatic queue_find();
        int k;
        if ($urandom_range(9) < 3) begin
            k = $urandom_range(BUILTIN_COUNT - 1);
            queue_op(FUNC_FIND, BUILTIN_X[k], BUILTIN_Y[k], '0);
        end else begin
            queue_op(FUNC_FIND, rand_coord(), rand_coord(), '0);
        end
    endtask

    task automatic queue_any();
        int r;
        r = $urandom_range(99);
        if (r < 35) queue_find();
        else if (r < 50) queue_op(FUNC_REMOVE, '0, '0, pick_index());
        else if (r < 65) queue_op(FUNC_TAKE, '0, '0, pick_index());
        else if (r < 90) queue_op(FUNC_APPEND, rand_coord(), rand_coord(), '0);
        else if (r < 94) queue_op(FUNC_REINIT, '0, '0, '0);
        else queue_op(FUNC_BITS'(FUNC_REINIT + $urandom_range(3, 1)), '0, '0, '0);
    endtask

    // random sequences of well-formed bursts plus loose noise
    task automatic random_bursts(int n);
        int stop;
        int kind;
        stop = cmds_queued + n;
        while (cmds_queued < stop) begin
            kind = $urandom_range(99);
            if (kind < 40) begin
                // loose mix of every operation
                repeat ($urandom_range(8, 1)) queue_any();
            end else if (kind < 60) begin
                // run of searches
                repeat ($urandom_range(6, 2)) queue_find();
            end else if (kind < 75) begin
                // fill to the brim, then one append too many
                while (plan_live < MAX_POINTS_DEF)
                    queue_op(FUNC_APPEND, rand_coord(), rand_coord(), '0);
                queue_op(FUNC_APPEND, rand_coord(), rand_coord(), '0);
                queue_find();
            end else if (kind < 90) begin
                // drain, search the empty table, then the widest possible distance
                while (plan_live != 0)
                    queue_op($urandom_range(1) ? FUNC_TAKE : FUNC_REMOVE, '0, '0,
                             INDEX_BITS'($urandom_range(plan_live - 1)));
                queue_find();
                queue_op(FUNC_TAKE, '0, '0, INDEX_BITS'($urandom));
                queue_op(FUNC_APPEND, COORD_MAX, COORD_MAX, '0);
                queue_op(FUNC_FIND, COORD_MIN, COORD_MIN, '0);
            end else begin
                queue_op(FUNC_REINIT, '0, '0, '0);
                queue_find();
            end
        end
    endtask

    // take-heavy traffic with no reload, long enough to saturate the taken counter
    task automatic hoard_takes(int n);
        int r;
        repeat (n) begin
            r = $urandom_range(99);
            if (plan_live == 0)
                queue_op(FUNC_APPEND, rand_coord(), rand_coord(), '0);
            else if (r < 52 || plan_live == MAX_POINTS_DEF)
                queue_op(FUNC_TAKE, '0, '0, INDEX_BITS'($urandom_range(plan_live - 1)));
            else if (r < 96)
                queue_op(FUNC_APPEND, rand_coord(), rand_coord(), '0);
            else
                queue_find();
        end
    endtask

    // wait until every queued word has produced its result
    task automatic settle();
        while (results_seen < cmds_queued) @(posedge i_clk);
    endtask

    // write both fallback registers, block idle
    task automatic set_fallback(logic signed [FIELD_BITS-1:0] x,
                                logic signed [FIELD_BITS-1:0] y);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_FALLBACK_X;
        i_cfg_data  <= x;
        @(posedge i_clk);
        i_cfg_index <= CFG_FALLBACK_Y;
        i_cfg_data  <= y;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        fb_x = x;
        fb_y = y;
        settings_used++;
    endtask

    task automatic flag(string what);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) $display("error: %s", what);
    endtask

    task automatic check_field(string name, longint got, longint exp_v);
        if (got != exp_v)
            flag($sformatf("result %0d field %s: expected %0d, got %0d",
                           results_seen, name, exp_v, got));
    endtask

    // command driver, model updated as each word is accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                answers_due.push_back(table_apply(cur_cmd));
                cmds_taken++;
            end
            if (!cmd_if.valid || cmd_if.ready) begin
                if (cmd_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    cur_cmd = cmd_backlog.pop_front();
                    cmd_if.func        <= cur_cmd.func;
                    cmd_if.query_x     <= cur_cmd.qx;
                    cmd_if.query_y     <= cur_cmd.qy;
                    cmd_if.entry_index <= cur_cmd.idx;
                    cmd_if.new_x       <= cur_cmd.nx;
                    cmd_if.new_y       <= cur_cmd.ny;
                    cmd_if.valid       <= 1'b1;
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            hold_left = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                results_seen++;
                if (answers_due.size() == 0) begin
                    flag($sformatf("result %0d arrived with nothing expected", results_seen));
                end else begin
                    want = answers_due.pop_front();
                    check_field("status", res_if.status, want.status);
                    check_field("found_index", res_if.found_index, want.slot);
                    check_field("found_x", res_if.found_x, want.x);
                    check_field("found_y", res_if.found_y, want.y);
                    check_field("best_distance", res_if.best_distance, want.distance);
                    check_field("live_count", res_if.live_count, want.live);
                    check_field("taken_count", res_if.taken_count, want.taken);
                    if (want.status == STATUS_EMPTY) fallback_answers++;
                    if (want.status == STATUS_BAD) rejected_cmds++;
                    if (want.taken > taken_peak) taken_peak = want.taken;
                end
            end
            // long hold-off on request, otherwise random stalls
            if (hold_req) hold_left = HOLD_CYCLES;
            else if (hold_left != 0) hold_left--;
            res_if.ready <= (hold_left == 0) && ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus sequence
    initial begin
        int mark;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = CFG_FALLBACK_X;
        i_cfg_data         = '0;
        cmd_if.valid       = 1'b0;
        cmd_if.func        = FUNC_FIND;
        cmd_if.query_x     = '0;
        cmd_if.query_y     = '0;
        cmd_if.entry_index = '0;
        cmd_if.new_x       = '0;
        cmd_if.new_y       = '0;
        res_if.ready       = 1'b0;
        src_idle_pct       = 24;
        snk_idle_pct       = 73;
        hold_req           = 1'b0;
        quiet_cycles       = 0;
        taken_peak         = '0;
        load_builtin();
        plan_live = BUILTIN_COUNT;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: searches on the built-in table
        queue_op(FUNC_FIND, -16'sd60, 16'sd95, '0);     // exact hit on slot 0
        queue_op(FUNC_FIND, 16'sd0, 16'sd95, '0);       // several slots tie
        queue_op(FUNC_FIND, COORD_MAX, COORD_MAX, '0);
        queue_op(FUNC_FIND, COORD_MIN, COORD_MIN, '0);
        // removal, take, out-of-range slots
        queue_op(FUNC_REMOVE, '0, '0, 4'd0);
        queue_op(FUNC_TAKE, '0, '0, 4'd10);             // last live slot
        queue_op(FUNC_REMOVE, '0, '0, 4'd15);
        queue_op(FUNC_TAKE, '0, '0, 4'd10);             // equals live count
        // append up to full and one beyond
        queue_op(FUNC_APPEND, COORD_MAX, COORD_MIN, '0);
        queue_op(FUNC_APPEND, COORD_MIN, COORD_MAX, '0);
        queue_op(FUNC_APPEND, COORD_MAX, COORD_MAX, '0);
        queue_op(FUNC_APPEND, -16'sd1, 16'sd0, '0);
        queue_op(FUNC_APPEND, COORD_MIN, COORD_MIN, '0);
        queue_op(FUNC_APPEND, 16'sd7, -16'sd7, '0);
        queue_op(FUNC_APPEND, 16'sd1, 16'sd1, '0);
        queue_op(FUNC_FIND, COORD_MIN, COORD_MIN, '0);
        // spare operation codes, then reload
        queue_op(FUNC_REINIT + 3'd1, '0, '0, '0);
        queue_op(FUNC_REINIT + 3'd2, '0, '0, '0);
        queue_op(FUNC_REINIT + 3'd3, '0, '0, '0);
        queue_op(FUNC_REINIT, '0, '0, '0);
        queue_op(FUNC_FIND, 16'sd15, 16'sd120, '0);

        // sender gaps light, receiver stalls heavy
        random_bursts(300);
        settle();
        set_fallback(COORD_MIN, COORD_MAX);
        random_bursts(300);
        settle();

        // the other way round, with a sender pause until all results are in
        src_idle_pct <= 73;
        snk_idle_pct <= 24;
        set_fallback(COORD_MAX, COORD_MIN);
        random_bursts(200);
        settle();
        random_bursts(200);
        settle();

        // no idling; long receiver hold-off while the sender keeps offering
        src_idle_pct <= 0;
        snk_idle_pct <= 0;
        set_fallback(FIELD_BITS'($urandom), FIELD_BITS'($urandom));
        hoard_takes(650);
        mark = cmds_taken + 150;
        while (cmds_taken < mark) @(posedge i_clk);
        hold_req <= 1'b1;
        @(posedge i_clk);
        hold_req <= 1'b0;
        settle();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (answers_due.size() != 0)
            flag($sformatf("%0d results never arrived", answers_due.size()));

        $display("run covered %0d command words and %0d result words over %0d fallback settings",
                 cmds_taken, results_seen, settings_used + 1);
        $display("%0d empty-table answers, %0d rejected words, taken counter peaked at %0d",
                 fallback_answers, rejected_cmds, taken_peak);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
